/* src/ua128_pkg.sv */
// Shared types and constants for the 128-bit unsigned ALU.
package ua128_pkg;

  localparam int unsigned DataWidth  = 128;
  localparam int unsigned HalfWidth  = 64;
  localparam int unsigned ShiftWidth = 7;
  localparam int unsigned OpWidth    = 4;

  typedef logic [DataWidth-1:0] word_t;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_AND = 4'd5,
    OP_OR  = 4'd6,
    OP_XOR = 4'd7,
    OP_NOT = 4'd8,
    OP_SHL = 4'd9,
    OP_SHR = 4'd10,
    OP_CMP = 4'd11
  } op_t;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_MUL  = 2'd1,
    MODE_DIV  = 2'd2
  } mode_t;

  // Control that travels with each word down the cell chain.
  typedef struct packed {
    logic  valid;
    mode_t mode;
    logic  want_quo;
    logic  equal;
    logic  greater;
    logic  less;
    logic  div_by_zero;
  } ctl_t;

endpackage

/* src/unsigned_alu_128.sv */
// Top level of the 128-bit unsigned ALU: input stage, cell chain and output register.
// A word passes through one input stage, 128 cells (one per operand bit of the
// multiply or divide) and one output register. Throughput is one word per cycle for
// every opcode; busy is always low. The synchronous active-low reset clears the control
// fields (valid bits and flags) along the chain; the data registers are not reset.
// Results are presented for exactly one cycle; the receiver cannot stall them.
module unsigned_alu_128
  import ua128_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [OpWidth-1:0]    in_operation,
  input  logic [HalfWidth-1:0]  in_a_low,
  input  logic [HalfWidth-1:0]  in_a_high,
  input  logic [HalfWidth-1:0]  in_b_low,
  input  logic [HalfWidth-1:0]  in_b_high,
  input  logic [ShiftWidth-1:0] in_shift_amount,
  output logic                  out_valid,
  output logic [HalfWidth-1:0]  out_result_low,
  output logic [HalfWidth-1:0]  out_result_high,
  output logic                  out_equal,
  output logic                  out_greater,
  output logic                  out_less,
  output logic                  out_div_by_zero
);

  localparam int unsigned Latency = DataWidth + 2;

  // Each position of the chain carries a word's control, operands and partial results.
  // Position 0 is the input stage; position k+1 is the output of cell k.
  ctl_t  ctl_q [DataWidth+1];
  word_t a_q   [DataWidth+1];
  word_t b_q   [DataWidth+1];
  word_t acc_q [DataWidth+1];
  word_t quo_q [DataWidth+1];

  ctl_t  out_ctl_r;
  word_t out_res_r;
  word_t out_res_nxt;

  // Every opcode takes the same path, so a new word can enter in every cycle.
  assign busy = 1'b0;

  // The input stage resolves the pass-through operations and divide by zero,
  // and marks multiply and divide words for the cell chain.
  ua128_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .operation    (in_operation),
    .a_in         ({in_a_high, in_a_low}),
    .b_in         ({in_b_high, in_b_low}),
    .shift_amount (in_shift_amount),
    .ctl_r        (ctl_q[0]),
    .a_r          (a_q[0]),
    .b_r          (b_q[0]),
    .acc_r        (acc_q[0])
  );

  // The quotient starts empty; each divide cell shifts in one quotient bit.
  assign quo_q[0] = '0;

  // Cell k handles multiplier bit k, or dividend bit 127-k for a divide.
  // Pass-through words simply ride along with their precomputed result.
  for (genvar k = 0; k < DataWidth; k++) begin : g_cell
    ua128_cell #(
      .BIT_IDX (k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_in (ctl_q[k]),
      .a_in   (a_q[k]),
      .b_in   (b_q[k]),
      .acc_in (acc_q[k]),
      .quo_in (quo_q[k]),
      .ctl_r  (ctl_q[k+1]),
      .a_r    (a_q[k+1]),
      .b_r    (b_q[k+1]),
      .acc_r  (acc_q[k+1]),
      .quo_r  (quo_q[k+1])
    );
  end

  // A divide delivers the quotient or the remainder; everything else the accumulator.
  assign out_res_nxt = (ctl_q[DataWidth].mode == MODE_DIV && ctl_q[DataWidth].want_quo)
                       ? quo_q[DataWidth] : acc_q[DataWidth];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ctl_r <= '0;
    end else begin
      out_ctl_r <= ctl_q[DataWidth];
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid       = out_ctl_r.valid;
  assign out_result_low  = out_res_r[HalfWidth-1:0];
  assign out_result_high = out_res_r[DataWidth-1:HalfWidth];
  assign out_equal       = out_ctl_r.equal;
  assign out_greater     = out_ctl_r.greater;
  assign out_less        = out_ctl_r.less;
  assign out_div_by_zero = out_ctl_r.div_by_zero;

  // The compare flags are exclusive.
  a_cmp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_equal, out_greater, out_less}))
    else $error("compare flags not exclusive");

  // Divide by zero never comes with compare flags.
  a_dz_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_by_zero) |-> !(out_equal || out_greater || out_less))
    else $error("divide by zero with compare flags");

  // Every result strobe stems from a word accepted with start.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, Latency))
    else $error("result strobe without matching accepted word");

  // A word accepted after reset is not lost in the chain and comes out as a result strobe.
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_q[0].valid |=> ##(Latency-2) out_valid)
    else $error("word lost in the cell chain");

endmodule

/* src/ua128_front.sv */
// Input stage: decodes the opcode and computes the pass-through operations.
module ua128_front
  import ua128_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [OpWidth-1:0]    operation,
  input  word_t                 a_in,
  input  word_t                 b_in,
  input  logic [ShiftWidth-1:0] shift_amount,
  output ctl_t                  ctl_r,
  output word_t                 a_r,
  output word_t                 b_r,
  output word_t                 acc_r
);

  ctl_t  ctl_nxt;
  word_t acc_nxt;
  logic  b_zero;

  assign b_zero = (b_in == '0);

  always_comb begin
    ctl_nxt       = '0;
    ctl_nxt.valid = start;
    ctl_nxt.mode  = MODE_PASS;
    acc_nxt       = '0;
    unique case (operation)
      OP_ADD: acc_nxt = a_in + b_in;
      OP_SUB: acc_nxt = a_in - b_in;
      OP_MUL: ctl_nxt.mode = MODE_MUL;
      OP_DIV, OP_MOD: begin
        ctl_nxt.want_quo = (operation == OP_DIV);
        if (b_zero) begin
          ctl_nxt.div_by_zero = 1'b1;
          acc_nxt = (operation == OP_DIV) ? '1 : a_in;
        end else begin
          ctl_nxt.mode = MODE_DIV;
        end
      end
      OP_AND: acc_nxt = a_in & b_in;
      OP_OR:  acc_nxt = a_in | b_in;
      OP_XOR: acc_nxt = a_in ^ b_in;
      OP_NOT: acc_nxt = ~a_in;
      OP_SHL: acc_nxt = a_in << shift_amount;
      OP_SHR: acc_nxt = a_in >> shift_amount;
      OP_CMP: begin
        ctl_nxt.equal   = (a_in == b_in);
        ctl_nxt.greater = (a_in > b_in);
        ctl_nxt.less    = (a_in < b_in);
      end
      default: acc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
    a_r   <= a_in;
    b_r   <= b_in;
    acc_r <= acc_nxt;
  end

endmodule

/* src/ua128_cell.sv */
// One cell of the chain: one shift-add multiply step or one restoring divide step.
module ua128_cell
  import ua128_pkg::*;
#(
  parameter int unsigned BIT_IDX = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  ctl_t  ctl_in,
  input  word_t a_in,
  input  word_t b_in,
  input  word_t acc_in,
  input  word_t quo_in,
  output ctl_t  ctl_r,
  output word_t a_r,
  output word_t b_r,
  output word_t acc_r,
  output word_t quo_r
);

  word_t              shifted;
  logic [DataWidth:0] diff;
  logic               ge;
  word_t              acc_nxt;
  word_t              quo_nxt;
  word_t              a_nxt;

  // The divide step shifts the next dividend bit into the partial remainder.
  assign shifted = {acc_in[DataWidth-2:0], a_in[DataWidth-1]};
  assign diff    = {acc_in[DataWidth-1], shifted} - {1'b0, b_in};
  assign ge      = ~diff[DataWidth];

  always_comb begin
    acc_nxt = acc_in;
    quo_nxt = quo_in;
    a_nxt   = a_in;
    unique case (ctl_in.mode)
      MODE_MUL: begin
        a_nxt = a_in << 1;
        if (b_in[BIT_IDX[ShiftWidth-1:0]]) begin
          acc_nxt = acc_in + a_in;
        end
      end
      MODE_DIV: begin
        a_nxt   = a_in << 1;
        acc_nxt = ge ? diff[DataWidth-1:0] : shifted;
        quo_nxt = {quo_in[DataWidth-2:0], ge};
      end
      default: acc_nxt = acc_in;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
    a_r   <= a_nxt;
    b_r   <= b_in;
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
  end

endmodule
